@@ hw/rtl/hmba_pkg.sv @@
// Package for the histogram mode-bin average block.
// Holds payload structs, controller states, command/status structs and constants.
// No dependencies.
package hmba_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int BIN_WIDTH_W     = 16;
   localparam int COUNT_W         = 8;
   localparam int SUM_W           = 40;
   localparam int MODE_BIN_W      = 5;
   localparam int DIV_CNT_W       = 6;

   localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RESET = 16'd100;
   localparam logic [COUNT_W-1:0]     COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   mode_mean;
      logic [MODE_BIN_W-1:0] mode_bin;
      logic [COUNT_W-1:0]    mode_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIN,
      ST_READ,
      ST_UPDATE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic bin_step;
      logic rd_acc;
      logic update;
      logic rd_scan;
      logic scan_cmp;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bin_done;
      logic last;
      logic scan_done;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/hmba_ctrl.sv @@
// Controller for the histogram mode-bin average block.
// Sequences binning, bin update, mode scan, mean division and result load.
// Depends on hmba_pkg.
module hmba_ctrl
   import hmba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            if (sts.bin_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = sts.last ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = sts.scan_done ? ST_DIV : ST_SCAN_RD;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_BIN: begin
            cmd.bin_step = 1'b1;
         end
         ST_READ: begin
            cmd.rd_acc = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SCAN_RD: begin
            cmd.rd_scan = 1'b1;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/hmba_dp.sv @@
// Datapath for the histogram mode-bin average block.
// Bin index divider, bin memory, mode scan, mean divider and result register.
// Depends on hmba_pkg.
module hmba_dp
   import hmba_pkg::*;
#(
   parameter int NUM_BINS    = 21,
   parameter int MAX_SAMPLES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   input  logic                   csr_we,
   input  logic [BIN_WIDTH_W-1:0] csr_wdata,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   localparam int IDX_W   = $clog2(NUM_BINS);
   localparam int BIT_W   = (IDX_W > 1) ? $clog2(IDX_W) : 1;
   localparam int TOT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int ENTRY_W = COUNT_W + SUM_W;
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

   logic [BIN_WIDTH_W-1:0] bin_width_ff;
   logic [BIN_WIDTH_W-1:0] width_ff;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic                   last_ff;
   logic [SAMPLE_W-1:0]    rem_ff, rem_in;
   logic [IDX_W-1:0]       quo_ff, quo_in;
   logic                   over_ff;
   logic [BIT_W-1:0]       bit_ff;
   logic [BIN_WIDTH_W-1:0] width_eff;
   logic [SAMPLE_W-1:0]    trial_div;
   logic [IDX_W-1:0]       bin_idx;

   logic [ENTRY_W-1:0]     mem [NUM_BINS];
   logic [NUM_BINS-1:0]    valid_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;
   logic [COUNT_W-1:0]     entry_cnt;
   logic [SUM_W-1:0]       entry_sum;
   logic [TOT_W-1:0]       total_ff;
   logic                   do_acc;

   logic [IDX_W-1:0]       scan_ff;
   logic [COUNT_W-1:0]     best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]       best_sum_ff, best_sum_in;

   logic [SUM_W-1:0]       quot_ff;
   logic [COUNT_W-1:0]     drem_ff;
   logic [DIV_CNT_W-1:0]   dstep_ff;
   logic [COUNT_W:0]       div_trial;
   logic                   div_ge;

   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   assign width_eff = (bin_width_ff == '0) ? BIN_WIDTH_W'(1) : bin_width_ff;
   assign trial_div = SAMPLE_W'(width_ff) << bit_ff;
   assign bin_idx   = (over_ff || quo_ff > LAST_BIN) ? LAST_BIN : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_WIDTH_RESET;
      end else if (csr_we) begin
         bin_width_ff <= csr_wdata;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (rem_ff >= trial_div) begin
         rem_in = rem_ff - trial_div;
         quo_in = quo_ff | (IDX_W'(1) << bit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         width_ff  <= width_eff;
         sample_ff <= req_data.sample;
         last_ff   <= req_data.last;
         rem_ff    <= req_data.sample;
         quo_ff    <= '0;
         over_ff   <= req_data.sample >= (SAMPLE_W'(width_eff) << IDX_W);
         bit_ff    <= BIT_W'(IDX_W - 1);
      end else if (cmd.bin_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   assign rd_addr = cmd.rd_scan ? scan_ff : bin_idx;

   always_ff @(posedge clock) begin
      if (cmd.rd_acc || cmd.rd_scan) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign entry_cnt = rd_valid_ff ? rd_data_ff[SUM_W +: COUNT_W] : '0;
   assign entry_sum = rd_valid_ff ? rd_data_ff[SUM_W-1:0] : '0;
   assign do_acc    = (total_ff < TOT_W'(MAX_SAMPLES)) && (entry_cnt < COUNT_MAX);

   always_ff @(posedge clock) begin
      if (cmd.update && do_acc) begin
         mem[bin_idx] <= {entry_cnt + COUNT_W'(1), entry_sum + SUM_W'(sample_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else if (cmd.out_load) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else if (cmd.update && do_acc) begin
         valid_ff[bin_idx] <= 1'b1;
         total_ff          <= total_ff + TOT_W'(1);
      end
   end

   always_comb begin
      best_cnt_in = best_cnt_ff;
      best_idx_in = best_idx_ff;
      best_sum_in = best_sum_ff;
      if (cmd.update) begin
         best_cnt_in = '0;
         best_idx_in = '0;
         best_sum_in = '0;
      end else if (cmd.scan_cmp && entry_cnt > best_cnt_ff) begin
         best_cnt_in = entry_cnt;
         best_idx_in = scan_ff;
         best_sum_in = entry_sum;
      end
   end

   always_ff @(posedge clock) begin
      best_cnt_ff <= best_cnt_in;
      best_idx_ff <= best_idx_in;
      best_sum_ff <= best_sum_in;
      if (cmd.update) begin
         scan_ff <= '0;
      end else if (cmd.scan_cmp) begin
         scan_ff <= scan_ff + IDX_W'(1);
      end
   end

   assign div_trial = {drem_ff, quot_ff[SUM_W-1]};
   assign div_ge    = div_trial >= {1'b0, best_cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.scan_cmp && sts.scan_done) begin
         quot_ff  <= best_sum_in;
         drem_ff  <= '0;
         dstep_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff  <= {quot_ff[SUM_W-2:0], div_ge};
         drem_ff  <= div_ge ? COUNT_W'(div_trial - {1'b0, best_cnt_ff}) : div_trial[COUNT_W-1:0];
         dstep_ff <= dstep_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.mode_mean  <= (best_cnt_ff == '0) ? '0 : quot_ff[SAMPLE_W-1:0];
         rsp_data_ff.mode_bin   <= MODE_BIN_W'(best_idx_ff);
         rsp_data_ff.mode_count <= best_cnt_ff;
      end
   end

   assign sts.bin_done  = (bit_ff == '0);
   assign sts.last      = last_ff;
   assign sts.scan_done = (scan_ff == LAST_BIN);
   assign sts.div_done  = (dstep_ff == DIV_CNT_W'(SUM_W - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/histogram_mode_bin_average_top.sv @@
// Histogram mode-bin average: top level.
// Instantiates hmba_ctrl and hmba_dp; depends on hmba_pkg.
//
// Usage:
//   req channel (valid/ready) carries one timing sample and a last flag.
//   Each sample lands in bin sample / bin_width, clamped to the last bin.
//   rsp channel (valid/ready) carries, after each set, the truncated mean,
//   index and count of the first most populated bin.
//   csr_we/csr_wdata write bin_width (0 acts as 1); write only while idle.
// Sequence:
//   Each sample passes through the bin divider, one quotient bit per cycle,
//   then one read and one write of the single-port bin memory. A last sample
//   adds a scan (one memory read and compare per bin), a bit-serial mean
//   divider and a load of the result register, which waits while a
//   previous result is still held.
// Reset and stall:
//   Synchronous reset empties all bins and sets bin_width to 100.
//   The result register holds a transaction until rsp_ready; the next set is
//   accepted meanwhile, and only a second finished set waits for it.
module histogram_mode_bin_average_top
   import hmba_pkg::*;
#(
   parameter int NUM_BINS    = 21,
   parameter int MAX_SAMPLES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [BIN_WIDTH_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   hmba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hmba_dp #(
      .NUM_BINS    (NUM_BINS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/tb_histogram_mode_bin_average_top.sv @@
`timescale 1ns / 1ps
// Testbench for histogram_mode_bin_average_top: streams sets of timing samples with
// random idling on both channels and checks each mode-bin result against a local predictor.
// Depends on hmba_pkg and the histogram_mode_bin_average_top RTL.
module tb_histogram_mode_bin_average_top;
   import hmba_pkg::*;

   localparam int BINS         = 21;
   localparam int SET_LIMIT    = 128;
   localparam int SETTLE       = 120;
   localparam int RANDOM_ITEMS = 240;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [BIN_WIDTH_W-1:0] csr_wdata = '0;

   logic [BIN_WIDTH_W-1:0] cur_width;
   logic [COUNT_W-1:0]     hits [BINS];
   logic [SUM_W-1:0]       acc  [BINS];
   int unsigned            taken;
   rsp_type                pending_modes [$];
   int unsigned            mismatches      = 0;
   int unsigned            sent            = 0;
   int unsigned            rsp_hold_cycles = 0;
   int unsigned            rsp_stall       = 0;
   bit                     steady          = 1'b0;

   histogram_mode_bin_average_top #(
      .NUM_BINS   (BINS),
      .MAX_SAMPLES(SET_LIMIT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void clear_tally();
      int i;
      for (i = 0; i < BINS; i++) begin
         hits[i] = '0;
         acc[i]  = '0;
      end
      taken = 0;
   endfunction

   function automatic bit tally_sample(input req_type t, output rsp_type mode);
      logic [SAMPLE_W-1:0] w;
      logic [SAMPLE_W-1:0] idx;
      logic [SUM_W-1:0]    mean;
      int                  best;
      int                  i;
      w   = (cur_width == '0) ? SAMPLE_W'(1) : SAMPLE_W'(cur_width);
      idx = t.sample / w;
      if (idx >= BINS) begin
         idx = BINS - 1;
      end
      if (taken < SET_LIMIT && hits[idx] < COUNT_MAX) begin
         hits[idx] = hits[idx] + 1'b1;
         acc[idx]  = acc[idx] + SUM_W'(t.sample);
         taken++;
      end
      mode = '0;
      if (!t.last) begin
         return 1'b0;
      end
      best = 0;
      for (i = 1; i < BINS; i++) begin
         if (hits[i] > hits[best]) begin
            best = i;
         end
      end
      mean = (hits[best] != '0) ? acc[best] / SUM_W'(hits[best]) : '0;
      mode.mode_mean  = mean[SAMPLE_W-1:0];
      mode.mode_bin   = MODE_BIN_W'(best);
      mode.mode_count = hits[best];
      clear_tally();
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned pick_set_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 6);
      end
      if (roll < 97) begin
         return $urandom_range(7, 30);
      end
      return $urandom_range(SET_LIMIT - 2, SET_LIMIT + 12);
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample(input int unsigned home);
      int unsigned w;
      int unsigned roll;
      w    = (cur_width == '0) ? 1 : int'(cur_width);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return home * w + $urandom_range(0, w - 1);
      end
      if (roll < 85) begin
         return $urandom_range(0, BINS * w + w);
      end
      if (roll < 93) begin
         return $urandom();
      end
      return 32'hFFFF_FFFF - $urandom_range(0, 255);
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic ends_set);
      int unsigned gap;
      req_type     t;
      rsp_type     mode;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      t.sample = value;
      t.last   = ends_set;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      if (tally_sample(t, mode)) begin
         pending_modes.push_back(mode);
      end
      sent++;
   endtask

   task automatic send_set(input int unsigned len);
      int unsigned home;
      int unsigned k;
      home = $urandom_range(0, BINS - 1);
      for (k = 0; k < len; k++) begin
         send_sample(draw_sample(home), k == len - 1);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_modes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(input logic [BIN_WIDTH_W-1:0] w);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_width = w;
   endtask

   task automatic test_clamp_to_last_bin();
      send_sample(32'd0, 1'b0);
      send_sample(32'd99, 1'b0);
      send_sample(32'd100, 1'b0);
      send_sample(32'd2099, 1'b0);
      send_sample(32'd2100, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_tie_picks_lowest();
      send_sample(32'd2050, 1'b0);
      send_sample(32'd310, 1'b0);
      send_sample(32'd2099, 1'b0);
      send_sample(32'd305, 1'b1);
   endtask

   task automatic test_width_extremes();
      write_width(16'd1);
      send_sample(32'd0, 1'b0);
      send_sample(32'd20, 1'b0);
      send_sample(32'd21, 1'b1);
      write_width(16'hFFFF);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFE, 1'b0);
      send_sample(32'd0, 1'b1);
      write_width(16'd0);
      send_sample(32'd3, 1'b0);
      send_sample(32'd3, 1'b1);
      send_sample(32'd7, 1'b1);
   endtask

   task automatic test_rsp_hold_off();
      write_width(16'd10);
      rsp_hold_cycles = 1500;
      repeat (8) send_set(2);
      wait_drain();
   endtask

   task automatic test_set_overflow();
      int unsigned home;
      int unsigned k;
      home = $urandom_range(0, BINS - 1);
      for (k = 0; k < SET_LIMIT + 5; k++) begin
         send_sample(home * 10 + $urandom_range(0, 9), 1'b0);
      end
      send_sample(((home + 1) % BINS) * 10, 1'b1);
   endtask

   task automatic test_random_sets();
      logic [BIN_WIDTH_W-1:0] widths [6];
      int unsigned            budget;
      int                     p;
      widths[0] = 16'd1;
      widths[1] = 16'hFFFF;
      widths[2] = 16'd0;
      widths[3] = BIN_WIDTH_RESET;
      widths[4] = BIN_WIDTH_W'($urandom_range(2, 500));
      widths[5] = BIN_WIDTH_W'($urandom());
      for (p = 0; p < 6; p++) begin
         write_width(widths[p]);
         steady = (p == 3);
         budget = sent + RANDOM_ITEMS / 6;
         while (sent < budget) send_set(pick_set_len());
      end
      steady = 1'b0;
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                       input logic [SAMPLE_W-1:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_modes.size() == 0) begin
            $display("%0t: unexpected transaction: expected none actual mean %0d bin %0d count %0d",
                     $time, rsp_data.mode_mean, rsp_data.mode_bin, rsp_data.mode_count);
            mismatches++;
         end else begin
            want = pending_modes.pop_front();
            check_field("mode_mean", want.mode_mean, rsp_data.mode_mean);
            check_field("mode_bin", SAMPLE_W'(want.mode_bin), SAMPLE_W'(rsp_data.mode_bin));
            check_field("mode_count", SAMPLE_W'(want.mode_count),
                        SAMPLE_W'(rsp_data.mode_count));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      clear_tally();
      cur_width = BIN_WIDTH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_clamp_to_last_bin();
      test_tie_picks_lowest();
      test_width_extremes();
      test_rsp_hold_off();
      test_set_overflow();
      test_random_sets();
      wait_drain();
      if (mismatches == 0 && pending_modes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
